// ----- src/pcmn_pkg.sv -----
// ============================================================================
// pcmn_pkg
// Shared types and codes for the per-channel max normalizer: pass opcodes,
// controller states and the command/status bundles between control and data.
// ============================================================================
`default_nettype none

package pcmn_pkg;

    // Pass opcodes carried by each input item
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic measure;   // fold the input pixel into the running peaks
        logic load;      // latch dividends and divisors, restart the step counter
        logic step;      // run one quotient bit in all three dividers
        logic capture;   // move the finished quotients into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_step; // the step now running yields the final quotient bit
    } status_t;

endpackage

`default_nettype wire

// ----- src/pcmn_if.sv -----
// ============================================================================
// pcmn_if
// Valid/ready channels of the per-channel max normalizer: the pixel input
// channel and the normalized pixel output channel.
// ============================================================================
`default_nettype none

interface pcmn_in_if #(
    parameter int INPUT_BITS = 24
) ();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic                  start_of_frame;
    logic [INPUT_BITS-1:0] red_in;
    logic [INPUT_BITS-1:0] green_in;
    logic [INPUT_BITS-1:0] blue_in;

    modport source (
        output valid, opcode, start_of_frame, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_of_frame, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface pcmn_out_if #(
    parameter int OUTPUT_FRACTION_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic [OUTPUT_FRACTION_BITS:0] red_out;
    logic [OUTPUT_FRACTION_BITS:0] green_out;
    logic [OUTPUT_FRACTION_BITS:0] blue_out;

    modport source (
        output valid, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/pcmn_divider.sv -----
// ============================================================================
// pcmn_divider
// Restoring divider for one channel: floor(value * 2^F / peak), one quotient
// bit per step, saturated to 1.0 and forced to zero for a zero peak.
// ============================================================================
`default_nettype none

module pcmn_divider #(
    parameter int INPUT_BITS           = 24,
    parameter int OUTPUT_FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic                          step,
    input  wire logic [INPUT_BITS-1:0]         value,
    input  wire logic [INPUT_BITS-1:0]         peak,
    output logic      [OUTPUT_FRACTION_BITS:0] quotient
);

    localparam int FB = OUTPUT_FRACTION_BITS;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    logic [INPUT_BITS:0]   rem_reg, rem_next;
    logic [INPUT_BITS-1:0] div_reg;
    logic [FB:0]           q_reg, q_next;
    logic                  zero_reg;
    logic                  sat_reg;
    logic                  ge;
    logic [INPUT_BITS:0]   diff;
    logic [INPUT_BITS:0]   kept;

    // When value < 2*peak the remainder stays below the divisor after each
    // subtract, so doubling it fits in INPUT_BITS+1 bits.
    always_comb
    begin
        ge       = rem_reg >= {1'b0, div_reg};
        diff     = rem_reg - {1'b0, div_reg};
        kept     = ge ? diff : rem_reg;
        rem_next = {kept[INPUT_BITS-1:0], 1'b0};
        q_next   = {q_reg[FB-1:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= {1'b0, value};
            div_reg  <= peak;
            q_reg    <= '0;
            zero_reg <= (peak == '0);
            sat_reg  <= ({1'b0, value} >= {peak, 1'b0});
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        if (zero_reg)
            quotient = '0;
        else if (sat_reg || (q_reg > ONE))
            quotient = ONE;
        else
            quotient = q_reg;
    end

endmodule

`default_nettype wire

// ----- src/pcmn_datapath.sv -----
// ============================================================================
// pcmn_datapath
// Peak registers, three channel dividers, step counter and output register
// of the per-channel max normalizer.
// ============================================================================
`default_nettype none

module pcmn_datapath #(
    parameter int INPUT_BITS           = 24,
    parameter int OUTPUT_FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pcmn_pkg::cmd_t                cmd,
    output pcmn_pkg::status_t                  status,
    input  wire logic                          start_of_frame,
    input  wire logic [INPUT_BITS-1:0]         red_in,
    input  wire logic [INPUT_BITS-1:0]         green_in,
    input  wire logic [INPUT_BITS-1:0]         blue_in,
    output logic      [OUTPUT_FRACTION_BITS:0] red_out,
    output logic      [OUTPUT_FRACTION_BITS:0] green_out,
    output logic      [OUTPUT_FRACTION_BITS:0] blue_out
);

    import pcmn_pkg::*;

    localparam int FB = OUTPUT_FRACTION_BITS;
    localparam int CW = $clog2(FB + 1);
    localparam logic [CW-1:0] LAST = CW'(FB);

    logic [INPUT_BITS-1:0] red_peak_reg, green_peak_reg, blue_peak_reg;
    logic [INPUT_BITS-1:0] red_base, green_base, blue_base;
    logic [CW-1:0]         cnt_reg;
    logic [FB:0]           red_q, green_q, blue_q;
    logic [FB:0]           red_out_reg, green_out_reg, blue_out_reg;

    // Start of frame drops the old peaks before this pixel is measured
    assign red_base   = start_of_frame ? '0 : red_peak_reg;
    assign green_base = start_of_frame ? '0 : green_peak_reg;
    assign blue_base  = start_of_frame ? '0 : blue_peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_peak_reg   <= '0;
            green_peak_reg <= '0;
            blue_peak_reg  <= '0;
        end
        else if (cmd.measure)
        begin
            red_peak_reg   <= (red_in   > red_base)   ? red_in   : red_base;
            green_peak_reg <= (green_in > green_base) ? green_in : green_base;
            blue_peak_reg  <= (blue_in  > blue_base)  ? blue_in  : blue_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    assign status.last_step = (cnt_reg == LAST);

    pcmn_divider #(
        .INPUT_BITS           (INPUT_BITS),
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_div_red (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .value    (red_in),
        .peak     (red_peak_reg),
        .quotient (red_q)
    );

    pcmn_divider #(
        .INPUT_BITS           (INPUT_BITS),
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_div_green (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .value    (green_in),
        .peak     (green_peak_reg),
        .quotient (green_q)
    );

    pcmn_divider #(
        .INPUT_BITS           (INPUT_BITS),
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_div_blue (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.step),
        .value    (blue_in),
        .peak     (blue_peak_reg),
        .quotient (blue_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            red_out_reg   <= red_q;
            green_out_reg <= green_q;
            blue_out_reg  <= blue_q;
        end
    end

    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule

`default_nettype wire

// ----- src/pcmn_ctrl.sv -----
// ============================================================================
// pcmn_ctrl
// Controller of the per-channel max normalizer: input handshake, division
// sequencing and the output register's valid flag.
// ============================================================================
`default_nettype none

module pcmn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_opcode,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pcmn_pkg::cmd_t         cmd,
    input  wire pcmn_pkg::status_t status
);

    import pcmn_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_NORMALIZE)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.measure = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold the finished quotients until the output slot opens
                if (slot_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/per_channel_max_normalizer.sv -----
// ============================================================================
// per_channel_max_normalizer
// Two-pass RGB normalizer: measures per-channel peaks, then scales each
// pixel so that each channel's peak maps to 1.0.
// ============================================================================
// A frame is streamed twice. Measure items (opcode 0) raise the red, green
// and blue peaks and produce no output; start_of_frame on a measure item
// clears the peaks before that pixel is counted. The block can take a new
// item straight after a measure item. Normalize items (opcode 1) produce
// one output item holding floor(channel * 2^OUTPUT_FRACTION_BITS / peak)
// per channel in unsigned Q1.OUTPUT_FRACTION_BITS, saturated at 1.0, and 0
// for a channel whose peak is zero. A normalize item occupies the block
// from its accept and load, through three restoring dividers that run in
// lockstep and retire one quotient bit per cycle, to an emit state that
// moves the quotients into the output register. The output register lets
// the next item be accepted while a result still waits; a further
// normalize item waits in its emit state until that register is taken.
// Peaks reset to zero.
// ============================================================================
`default_nettype none

module per_channel_max_normalizer #(
    parameter int INPUT_BITS           = 24,
    parameter int OUTPUT_FRACTION_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcmn_in_if.sink    in_ch,
    pcmn_out_if.source out_ch
);

    import pcmn_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence the handshake and the division steps
    pcmn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Peaks, dividers and the output register
    pcmn_datapath #(
        .INPUT_BITS           (INPUT_BITS),
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .start_of_frame (in_ch.start_of_frame),
        .red_in         (in_ch.red_in),
        .green_in       (in_ch.green_in),
        .blue_in        (in_ch.blue_in),
        .red_out        (out_ch.red_out),
        .green_out      (out_ch.green_out),
        .blue_out       (out_ch.blue_out)
    );

endmodule

`default_nettype wire

// ----- src/pcmn_checker.sv -----
// ============================================================================
// pcmn_checker
// Port-level checks of the per-channel max normalizer, bound to the top.
// ============================================================================
`default_nettype none

module pcmn_checker #(
    parameter int OUTPUT_FRACTION_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          in_opcode,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [OUTPUT_FRACTION_BITS:0] red_out,
    input wire logic [OUTPUT_FRACTION_BITS:0] green_out,
    input wire logic [OUTPUT_FRACTION_BITS:0] blue_out
);

    import pcmn_pkg::*;

    localparam logic [OUTPUT_FRACTION_BITS:0] ONE = {1'b1, {OUTPUT_FRACTION_BITS{1'b0}}};

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // Results never exceed 1.0
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out <= ONE) && (green_out <= ONE) && (blue_out <= ONE))
        else $error("normalized value above 1.0");

    // A normalize item occupies the block: no input next cycle
    a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_NORMALIZE) |=> !in_ready)
        else $error("input accepted during division");

    // A measure item leaves the input ready in the next cycle
    a_measure_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_MEASURE) |=> in_ready)
        else $error("input stalled after a measure item");

endmodule

bind per_channel_max_normalizer pcmn_checker #(
    .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
) u_pcmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .red_out   (out_ch.red_out),
    .green_out (out_ch.green_out),
    .blue_out  (out_ch.blue_out)
);

`default_nettype wire

// ----- tb/per_channel_max_normalizer_tb.sv -----
// ============================================================================
// per_channel_max_normalizer_tb
// Self-checking bench for the two-pass per-channel max normalizer. It streams
// measure and normalize items, tracks the channel peaks in a local predictor,
// and compares every normalized output item against the predicted quotients.
// ============================================================================
`timescale 1ns / 1ps

module per_channel_max_normalizer_tb;

    import pcmn_pkg::*;

    localparam int IN_W         = 24;
    localparam int FRAC         = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 60;    // extra watch for stray output items after draining
    localparam int REPORT_MAX   = 10;

    localparam logic [IN_W-1:0]      CH_MAX = {IN_W{1'b1}};
    localparam logic [IN_W+FRAC-1:0] UNITY  = (IN_W+FRAC)'(1) << FRAC;

    typedef struct packed {
        logic [FRAC:0] red;
        logic [FRAC:0] green;
        logic [FRAC:0] blue;
    } norm_pixel_t;

    typedef struct packed {
        logic [IN_W-1:0] red;
        logic [IN_W-1:0] green;
        logic [IN_W-1:0] blue;
    } rgb_t;

    logic clk;
    logic rst_n;

    pcmn_in_if  #(.INPUT_BITS(IN_W))           in_ch ();
    pcmn_out_if #(.OUTPUT_FRACTION_BITS(FRAC)) out_ch ();

    per_channel_max_normalizer #(
        .INPUT_BITS           (IN_W),
        .OUTPUT_FRACTION_BITS (FRAC)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state: running peaks as the block should hold them
    logic [IN_W-1:0] peak_red;
    logic [IN_W-1:0] peak_green;
    logic [IN_W-1:0] peak_blue;

    // Normalized pixels still owed by the block, oldest first
    norm_pixel_t pending_pixels[$];

    int mismatch_count;
    int cycle_count;
    bit tx_burst;       // sender runs with no gaps while set

    // ------------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the block stops making progress
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("per_channel_max_normalizer_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // floor(value * 2^FRAC / peak), saturated at 1.0, zero for a zero peak
    function automatic logic [FRAC:0] scale_to_peak(logic [IN_W-1:0] value,
                                                    logic [IN_W-1:0] peak);
        logic [IN_W+FRAC-1:0] quotient;
        if (peak == '0)
            return '0;
        quotient = {value, {FRAC{1'b0}}} / peak;
        if (quotient > UNITY)
            quotient = UNITY;
        return quotient[FRAC:0];
    endfunction

    // Fold a measure item into the peaks, or queue the normalized pixel
    task automatic predict_pixel(logic op, logic sof, rgb_t px);
        norm_pixel_t np;
        if (op == OP_MEASURE)
        begin
            if (sof)
            begin
                peak_red   = '0;
                peak_green = '0;
                peak_blue  = '0;
            end
            if (px.red   > peak_red)   peak_red   = px.red;
            if (px.green > peak_green) peak_green = px.green;
            if (px.blue  > peak_blue)  peak_blue  = px.blue;
        end
        else
        begin
            np.red   = scale_to_peak(px.red,   peak_red);
            np.green = scale_to_peak(px.green, peak_green);
            np.blue  = scale_to_peak(px.blue,  peak_blue);
            pending_pixels.push_back(np);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Channel values biased toward the edges: zero, full scale, tiny, one bit
    function automatic logic [IN_W-1:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CH_MAX;
            2:       return IN_W'($urandom_range(0, 255));
            3:       return IN_W'(1) << $urandom_range(0, IN_W - 1);
            default: return IN_W'($urandom());
        endcase
    endfunction

    function automatic rgb_t pick_rgb();
        rgb_t px;
        px.red   = pick_channel();
        px.green = pick_channel();
        px.blue  = pick_channel();
        return px;
    endfunction

    function automatic rgb_t make_rgb(logic [IN_W-1:0] r, logic [IN_W-1:0] g,
                                      logic [IN_W-1:0] b);
        rgb_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // Present one item and hold it until the block takes it. Called and
    // returning at a rising edge; valid stays high so that a back-to-back
    // item follows without a bubble. Whoever drives next lowers it.
    task automatic send_pixel(logic op, logic sof, rgb_t px);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.start_of_frame <= sof;
        in_ch.red_in         <= px.red;
        in_ch.green_in       <= px.green;
        in_ch.blue_in        <= px.blue;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_pixel(op, sof, px);
    endtask

    // Hold off the sender until every owed pixel has come out; always
    // advance at least one edge so the next driver starts on a fresh edge
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure and the result checker
    // ------------------------------------------------------------------------
    task automatic check_pixel();
        norm_pixel_t want;
        norm_pixel_t got;
        got.red   = out_ch.red_out;
        got.green = out_ch.green_out;
        got.blue  = out_ch.blue_out;
        if (pending_pixels.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("unexpected output item: r=%0d g=%0d b=%0d",
                         got.red, got.green, got.blue);
            return;
        end
        want = pending_pixels.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                         want.red, want.green, want.blue,
                         got.red, got.green, got.blue);
        end
    endtask

    initial
    begin
        int stall_left;
        bit rx_burst;
        logic next_ready;
        stall_left = 0;
        rx_burst   = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                check_pixel();
            // Switch between stalling and free-running stretches now and then
            if ($urandom_range(0, 399) == 0)
                rx_burst = !rx_burst;
            if (stall_left > 0)
            begin
                next_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                next_ready = 1'b1;
                if (!rx_burst && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
            out_ch.ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Normalize straight after reset: all peaks are zero, so outputs are zero
    task automatic test_normalize_after_reset();
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(CH_MAX, 24'h123456, 24'h000001));
        send_pixel(OP_NORMALIZE, 1'b1, make_rgb(24'h000000, CH_MAX, 24'h800000));
    endtask

    // Full-scale peaks against full-scale, zero and smallest values, then peaks of one
    task automatic test_field_extremes();
        send_pixel(OP_MEASURE,   1'b1, make_rgb(CH_MAX, CH_MAX, CH_MAX));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(CH_MAX, CH_MAX, CH_MAX));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000000, 24'h000001, 24'h7FFFFF));
        send_pixel(OP_MEASURE,   1'b1, make_rgb(24'h000001, 24'h000001, 24'h000001));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000001, 24'h000000, 24'h000001));
    endtask

    // A channel whose peak is zero yields zero for that channel
    task automatic test_zero_peak();
        send_pixel(OP_MEASURE,   1'b1, make_rgb(24'h000000, 24'h000005, 24'h000000));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000000, 24'h000003, 24'h000000));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(CH_MAX, 24'h000005, 24'h00ABCD));
    endtask

    // Pixels brighter than the measured peak saturate at 1.0
    task automatic test_above_peak();
        send_pixel(OP_MEASURE,   1'b1, make_rgb(24'h000100, 24'h010000, 24'h000003));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000101, CH_MAX, 24'h000002));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000100, 24'h010001, 24'h000004));
    endtask

    // Start flag on a normalize item must leave the peaks alone
    task automatic test_start_flag_in_normalize();
        send_pixel(OP_MEASURE,   1'b1, make_rgb(24'h400000, 24'h200000, 24'h100000));
        send_pixel(OP_NORMALIZE, 1'b1, make_rgb(24'h200000, 24'h200000, 24'h080000));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h100000, 24'h100000, 24'h100000));
    endtask

    // Start flag on a measure item clears peaks before that pixel counts;
    // then let the output side drain with the sender parked
    task automatic test_start_flag_clears();
        send_pixel(OP_MEASURE,   1'b0, make_rgb(CH_MAX, CH_MAX, CH_MAX));
        send_pixel(OP_MEASURE,   1'b1, make_rgb(24'h000010, 24'h000020, 24'h000030));
        send_pixel(OP_MEASURE,   1'b0, make_rgb(24'h000008, 24'h000040, 24'h000001));
        send_pixel(OP_NORMALIZE, 1'b0, make_rgb(24'h000008, 24'h000020, 24'h000030));
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random frames: mostly measure-then-normalize passes over the same
    // pixels, with some noise items and broken frames mixed in
    // ------------------------------------------------------------------------
    task automatic test_random_frames();
        rgb_t frame[$];
        rgb_t px;
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 32)
                                                : $urandom_range(1, 6);
                frame.delete();
                for (int i = 0; i < n; i++)
                    frame.push_back(pick_rgb());
                // Measure pass; start flag on the first pixel, rarely dropped
                for (int i = 0; i < n; i++)
                begin
                    send_pixel(OP_MEASURE,
                               (i == 0) ? ($urandom_range(0, 19) != 0) : 1'b0,
                               frame[i]);
                    sent++;
                end
                // Normalize pass; sometimes swap in a fresh pixel or stray flag
                for (int i = 0; i < n; i++)
                begin
                    px = ($urandom_range(0, 9) == 0) ? pick_rgb() : frame[i];
                    send_pixel(OP_NORMALIZE, ($urandom_range(0, 9) == 0), px);
                    sent++;
                end
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    send_pixel(1'($urandom()), 1'($urandom()), pick_rgb());
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        tx_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count = 0;
        tx_burst       = 1'b0;
        peak_red       = '0;
        peak_green     = '0;
        peak_blue      = '0;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.opcode         <= OP_MEASURE;
        in_ch.start_of_frame <= 1'b0;
        in_ch.red_in         <= '0;
        in_ch.green_in       <= '0;
        in_ch.blue_in        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_normalize_after_reset();
        test_field_extremes();
        test_zero_peak();
        test_above_peak();
        test_start_flag_in_normalize();
        test_start_flag_clears();
        test_random_frames();

        // Drain, then watch a while longer for stray output items
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected output items never arrived",
                     pending_pixels.size());
        end

        if (mismatch_count == 0)
            $display("per_channel_max_normalizer_tb: PASS");
        else
            $display("per_channel_max_normalizer_tb: FAIL");
        $finish;
    end

endmodule
